// ----- design/hsb_rgb_color_resolve_defines.svh -----
// Assertion helpers used by hsb_rgb_color_resolve.sv.
`ifndef HSB_RGB_COLOR_RESOLVE_DEFINES_SVH
`define HSB_RGB_COLOR_RESOLVE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HSB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define HSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/hsb_pkg.sv -----
package hsb_pkg;

  typedef struct packed {
    logic               opcode;
    logic signed [23:0] chan_a;
    logic signed [23:0] chan_b;
    logic signed [23:0] chan_c;
    logic signed [23:0] alpha_value;
  } req_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha_out;
  } result_t;

  localparam int CHAN_W = 24;
  localparam int OUT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam logic [OUT_W-1:0] ONE_Q15 = 16'd32768;

  localparam int CLAMP_QW = 17;
  localparam int HUE_QW = 24;
  localparam int FRAC_QW = 19;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_THIRD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_ALPHA = 3'd4;

  localparam logic [CHAN_W-1:0] RANGE_RESET = 24'd65280;

endpackage

// ----- design/hsb_rgb_color_resolve.sv -----
// Throughput: one request per clock cycle outside reset (busy follows rst), set by the bit-per-stage divider pipelines.
// The hue path (24-stage modulo, a wrap stage, a 19-stage fraction divide) sets the depth.
// The receiver cannot stall; every request gives one result on done.
// Synchronous reset clears the pipeline valids and loads the register defaults.
`include "hsb_rgb_color_resolve_defines.svh"

module hsb_rgb_color_resolve (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  hsb_pkg::req_t                      req,
  output logic                               done,
  output hsb_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsb_pkg::CHAN_W-1:0]         cfg_data
);

  localparam int CW = hsb_pkg::CHAN_W;
  localparam int OW = hsb_pkg::OUT_W;
  localparam int DLY = hsb_pkg::HUE_QW + 1 + hsb_pkg::FRAC_QW - hsb_pkg::CLAMP_QW;
  localparam int LAT = 1 + hsb_pkg::HUE_QW + 1 + hsb_pkg::FRAC_QW + 3;

  logic          hsb_sel;
  logic [CW-1:0] range_first;
  logic [CW-1:0] range_second;
  logic [CW-1:0] range_third;
  logic [CW-1:0] range_alpha;

  assign cfg_ready = 1'b1;
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsb_sel <= 1'b0;
      range_first <= hsb_pkg::RANGE_RESET;
      range_second <= hsb_pkg::RANGE_RESET;
      range_third <= hsb_pkg::RANGE_RESET;
      range_alpha <= hsb_pkg::RANGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hsb_pkg::REG_COLOR_MODE: hsb_sel <= cfg_data[0];
        hsb_pkg::REG_RANGE_FIRST: range_first <= cfg_data;
        hsb_pkg::REG_RANGE_SECOND: range_second <= cfg_data;
        hsb_pkg::REG_RANGE_THIRD: range_third <= cfg_data;
        hsb_pkg::REG_RANGE_ALPHA: range_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  logic          in_v;
  hsb_pkg::req_t in_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_q <= req;
    end
  end

  logic [CW-1:0] chan [4];
  logic [CW-1:0] dens [4];
  logic [OW-1:0] cl_now [4];

  assign chan[0] = in_q.chan_a;
  assign chan[1] = in_q.chan_b;
  assign chan[2] = in_q.chan_c;
  assign chan[3] = in_q.alpha_value;
  assign dens[0] = range_first;
  assign dens[1] = range_second;
  assign dens[2] = range_third;
  assign dens[3] = range_alpha;

  for (genvar c = 0; c < 4; c++) begin : g_clamp
    logic [CW-2:0]              xa;
    logic                       zero_f;
    logic                       sat_f;
    logic [1:0]                 side_o;
    logic [hsb_pkg::CLAMP_QW-1:0] q;
    logic [CW-1:0]              r_unused;
    logic                       v_unused;

    assign xa = chan[c][CW-2:0];
    assign zero_f = chan[c][CW-1] || (chan[c] == '0);
    assign sat_f = (dens[c] == '0) || ({3'b000, xa} >= {dens[c], 2'b00});

    hsb_pipe_div #(
      .NW(CW - 1 + 15),
      .DW(CW),
      .QW(hsb_pkg::CLAMP_QW),
      .SW(2)
    ) u_div (
      .clk(clk),
      .rst(rst),
      .in_valid(in_v),
      .num({xa, 15'd0}),
      .den(dens[c]),
      .side_in({zero_f, sat_f}),
      .out_valid(v_unused),
      .quo(q),
      .rem(r_unused),
      .side_out(side_o)
    );

    always_comb begin
      priority if (side_o[1]) begin
        cl_now[c] = '0;
      end else if (side_o[0] || (q > 17'(hsb_pkg::ONE_Q15))) begin
        cl_now[c] = hsb_pkg::ONE_Q15;
      end else begin
        cl_now[c] = q[OW-1:0];
      end
    end
  end

  logic [3:0][OW-1:0] cl_d [DLY];

  always_ff @(posedge clk) begin
    cl_d[0] <= {cl_now[3], cl_now[2], cl_now[1], cl_now[0]};
    for (int i = 1; i < DLY; i++) begin
      cl_d[i] <= cl_d[i-1];
    end
  end

  logic          h_neg;
  logic [CW-1:0] h_abs;
  logic          d1_v;
  logic [CW-1:0] d1_rem;
  logic [2:0]    d1_side;
  logic [hsb_pkg::HUE_QW-1:0] d1_quo;

  assign h_neg = in_q.chan_a[CW-1];
  assign h_abs = h_neg ? CW'(-in_q.chan_a) : in_q.chan_a;

  hsb_pipe_div #(
    .NW(CW),
    .DW(CW),
    .QW(hsb_pkg::HUE_QW),
    .SW(3)
  ) u_hue_mod (
    .clk(clk),
    .rst(rst),
    .in_valid(in_v),
    .num(h_abs),
    .den(range_first),
    .side_in({in_q.opcode, h_neg, range_first == '0}),
    .out_valid(d1_v),
    .quo(d1_quo),
    .rem(d1_rem),
    .side_out(d1_side)
  );

  logic          w_v;
  logic [CW-1:0] w_r;
  logic [1:0]    w_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_v <= 1'b0;
    end else begin
      w_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= (d1_side[1] && d1_rem != '0) ? range_first - d1_rem : d1_rem;
    w_side <= {d1_side[2], d1_side[0]};
  end

  logic [CW+2:0] r6;
  logic          d2_v;
  logic [hsb_pkg::FRAC_QW-1:0] d2_quo;
  logic [CW-1:0] d2_rem;
  logic [1:0]    d2_side;

  assign r6 = {1'b0, w_r, 2'b00} + {2'b00, w_r, 1'b0};

  hsb_pipe_div #(
    .NW(CW + 3 + 16),
    .DW(CW),
    .QW(hsb_pkg::FRAC_QW),
    .SW(2)
  ) u_hue_frac (
    .clk(clk),
    .rst(rst),
    .in_valid(w_v),
    .num({r6, 16'd0}),
    .den(range_first),
    .side_in(w_side),
    .out_valid(d2_v),
    .quo(d2_quo),
    .rem(d2_rem),
    .side_out(d2_side)
  );

  logic [3:0][OW-1:0] cl_al;
  logic [2:0]    sec_n;
  logic [OW-1:0] f_n;
  logic [OW-1:0] s_n;
  logic [31:0]   sf_prod;
  logic [32:0]   sg_prod;

  assign cl_al = cl_d[DLY-1];
  assign sec_n = d2_side[0] ? 3'd0 : d2_quo[18:16];
  assign f_n = d2_side[0] ? '0 : d2_quo[15:0];
  assign s_n = cl_al[1];
  assign sf_prod = 32'(s_n) * 32'(f_n);
  assign sg_prod = 33'(s_n) * (33'd65536 - 33'(f_n));

  logic               m1_v;
  logic               m1_op;
  logic [2:0]         m1_sec;
  logic [3:0][OW-1:0] m1_cl;
  logic [OW-1:0]      m1_sf;
  logic [OW-1:0]      m1_sg;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else begin
      m1_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    m1_op <= d2_side[1];
    m1_sec <= sec_n;
    m1_cl <= cl_al;
    m1_sf <= sf_prod[31:16];
    m1_sg <= sg_prod[31:16];
  end

  logic [OW-1:0] v1;
  logic [31:0]   p_prod;
  logic [31:0]   q_prod;
  logic [31:0]   t_prod;

  assign v1 = m1_cl[2];
  assign p_prod = 32'(v1) * 32'(hsb_pkg::ONE_Q15 - m1_cl[1]);
  assign q_prod = 32'(v1) * 32'(hsb_pkg::ONE_Q15 - m1_sf);
  assign t_prod = 32'(v1) * 32'(hsb_pkg::ONE_Q15 - m1_sg);

  logic               m2_v;
  logic               m2_op;
  logic [2:0]         m2_sec;
  logic [3:0][OW-1:0] m2_cl;
  logic [OW-1:0]      m2_p;
  logic [OW-1:0]      m2_q;
  logic [OW-1:0]      m2_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    m2_op <= m1_op;
    m2_sec <= m1_sec;
    m2_cl <= m1_cl;
    m2_p <= p_prod[30:15];
    m2_q <= q_prod[30:15];
    m2_t <= t_prod[30:15];
  end

  hsb_pkg::result_t res_n;
  logic [OW-1:0]    v2;

  assign v2 = m2_cl[2];

  always_comb begin
    res_n.alpha_out = m2_cl[3];
    if (m2_op) begin
      res_n.red = v2;
      res_n.green = v2;
      res_n.blue = v2;
    end else if (hsb_sel) begin
      unique case (m2_sec)
        3'd0: begin
          res_n.red = v2; res_n.green = m2_t; res_n.blue = m2_p;
        end
        3'd1: begin
          res_n.red = m2_q; res_n.green = v2; res_n.blue = m2_p;
        end
        3'd2: begin
          res_n.red = m2_p; res_n.green = v2; res_n.blue = m2_t;
        end
        3'd3: begin
          res_n.red = m2_p; res_n.green = m2_q; res_n.blue = v2;
        end
        3'd4: begin
          res_n.red = m2_t; res_n.green = m2_p; res_n.blue = v2;
        end
        default: begin
          res_n.red = v2; res_n.green = m2_p; res_n.blue = m2_q;
        end
      endcase
    end else begin
      res_n.red = m2_cl[0];
      res_n.green = m2_cl[1];
      res_n.blue = v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_n;
  end

  `HSB_ASSERT_NOW(a_done_latency, clk, rst, done, $past(start && !busy, LAT))
  `HSB_ASSERT_NOW(a_out_range, clk, rst, done, (result.red <= hsb_pkg::ONE_Q15) && (result.green <= hsb_pkg::ONE_Q15) && (result.blue <= hsb_pkg::ONE_Q15) && (result.alpha_out <= hsb_pkg::ONE_Q15))
  `HSB_ASSERT_NOW(a_gray_equal, clk, rst, done && $past(req.opcode, LAT), (result.red == result.green) && (result.green == result.blue))
  `HSB_ASSERT_NEXT(a_valid_flow, clk, rst, m2_v, done)

endmodule

// ----- design/hsb_pipe_div.sv -----
module hsb_pipe_div #(
  parameter int NW = 38,
  parameter int DW = 24,
  parameter int QW = 17,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic [SW-1:0] side_out
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld    [QW+1];
  logic [RW-1:0] rem_s  [QW+1];
  logic [QW-1:0] quo_s  [QW+1];
  logic [SW-1:0] side_s [QW+1];

  assign vld[0] = in_valid;
  assign rem_s[0] = RW'(num);
  assign quo_s[0] = '0;
  assign side_s[0] = side_in;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(den) << B;
    assign ge = rem_s[k] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_s[k+1] <= ge ? rem_s[k] - dsh : rem_s[k];
      quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
      side_s[k+1] <= side_s[k];
    end
  end

  assign out_valid = vld[QW];
  assign quo = quo_s[QW];
  assign rem = rem_s[QW][DW-1:0];
  assign side_out = side_s[QW];

endmodule

// ----- bench/tb_hsb_rgb_color_resolve.sv -----
`timescale 1ns / 1ps

class color_scoreboard;
  bit                 hsb_mode;
  longint             ranges[4];
  hsb_pkg::result_t   pending[$];
  int                 errors;

  function new();
    hsb_mode = 1'b0;
    foreach (ranges[i]) ranges[i] = hsb_pkg::RANGE_RESET;
    errors = 0;
  endfunction

  function void write_reg(logic [hsb_pkg::CFG_IDX_W-1:0] idx,
                          logic [hsb_pkg::CHAN_W-1:0] data);
    case (idx)
      hsb_pkg::REG_COLOR_MODE:   hsb_mode = data[0];
      hsb_pkg::REG_RANGE_FIRST:  ranges[0] = data;
      hsb_pkg::REG_RANGE_SECOND: ranges[1] = data;
      hsb_pkg::REG_RANGE_THIRD:  ranges[2] = data;
      hsb_pkg::REG_RANGE_ALPHA:  ranges[3] = data;
      default: ;
    endcase
  endfunction

  function longint clamp_q15(logic signed [hsb_pkg::CHAN_W-1:0] x, longint rng);
    longint q;
    if (x <= 0) return 0;
    if (rng == 0) return 32768;
    q = (longint'(x) <<< 15) / rng;
    return (q > 32768) ? 32768 : q;
  endfunction

  function void hue_to_rgb(logic signed [hsb_pkg::CHAN_W-1:0] hue, longint s, longint v,
                           output longint rgb[3]);
    longint r, r6, sector, f, sf, sg, p, q, t;
    sector = 0;
    f = 0;
    if (ranges[0] != 0) begin
      r = longint'(hue) % ranges[0];
      if (r < 0) r += ranges[0];
      r6 = r * 6;
      sector = r6 / ranges[0];
      f = ((r6 % ranges[0]) <<< 16) / ranges[0];
    end
    sf = (s * f) >>> 16;
    sg = (s * (65536 - f)) >>> 16;
    p = (v * (32768 - s)) >>> 15;
    q = (v * (32768 - sf)) >>> 15;
    t = (v * (32768 - sg)) >>> 15;
    case (sector)
      0: begin rgb[0] = v; rgb[1] = t; rgb[2] = p; end
      1: begin rgb[0] = q; rgb[1] = v; rgb[2] = p; end
      2: begin rgb[0] = p; rgb[1] = v; rgb[2] = t; end
      3: begin rgb[0] = p; rgb[1] = q; rgb[2] = v; end
      4: begin rgb[0] = t; rgb[1] = p; rgb[2] = v; end
      default: begin rgb[0] = v; rgb[1] = p; rgb[2] = q; end
    endcase
  endfunction

  function void note_request(hsb_pkg::req_t r);
    longint rgb[3];
    longint v3;
    hsb_pkg::result_t e;
    v3 = clamp_q15(r.chan_c, ranges[2]);
    if (r.opcode) begin
      rgb[0] = v3; rgb[1] = v3; rgb[2] = v3;
    end else if (hsb_mode) begin
      hue_to_rgb(r.chan_a, clamp_q15(r.chan_b, ranges[1]), v3, rgb);
    end else begin
      rgb[0] = clamp_q15(r.chan_a, ranges[0]);
      rgb[1] = clamp_q15(r.chan_b, ranges[1]);
      rgb[2] = v3;
    end
    e.red = rgb[0][15:0];
    e.green = rgb[1][15:0];
    e.blue = rgb[2][15:0];
    e.alpha_out = 16'(clamp_q15(r.alpha_value, ranges[3]));
    pending.insert(pending.size(), e);
  endfunction

  function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check(hsb_pkg::result_t got);
    hsb_pkg::result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result: red %0d green %0d blue %0d alpha %0d",
             got.red, got.green, got.blue, got.alpha_out);
      errors++;
      return;
    end
    e = pending.pop_front();
    compare_field("red", e.red, got.red);
    compare_field("green", e.green, got.green);
    compare_field("blue", e.blue, got.blue);
    compare_field("alpha_out", e.alpha_out, got.alpha_out);
  endfunction
endclass

module tb_hsb_rgb_color_resolve;
  localparam logic OP_COLOR = 1'b0;
  localparam logic OP_GRAY = 1'b1;
  localparam logic MODE_RGB = 1'b0;
  localparam logic MODE_HSB = 1'b1;
  localparam logic [hsb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [hsb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [hsb_pkg::CHAN_W-1:0] RANGE_MAX = 24'hFFFFFF;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 300000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  hsb_pkg::req_t req;
  logic done;
  hsb_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [hsb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hsb_pkg::CHAN_W-1:0] cfg_data;

  color_scoreboard sb = new();
  bit idle_enable = 1'b1;
  int cycles = 0;

  hsb_rgb_color_resolve DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_request(req);
    if (!rst && done) sb.check(result);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send(input hsb_pkg::req_t r);
    start <= 1'b1;
    req <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (idle_enable && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic op, input int a, input int b, input int c,
                             input int al);
    hsb_pkg::req_t r;
    r.opcode = op;
    r.chan_a = a[23:0];
    r.chan_b = b[23:0];
    r.chan_c = c[23:0];
    r.alpha_value = al[23:0];
    send(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hsb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hsb_pkg::CHAN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic mode, input logic [hsb_pkg::CHAN_W-1:0] r1,
                           input logic [hsb_pkg::CHAN_W-1:0] r2,
                           input logic [hsb_pkg::CHAN_W-1:0] r3,
                           input logic [hsb_pkg::CHAN_W-1:0] r4);
    drain();
    write_reg(hsb_pkg::REG_COLOR_MODE, {23'($urandom), mode});
    write_reg(hsb_pkg::REG_RANGE_FIRST, r1);
    write_reg(hsb_pkg::REG_RANGE_SECOND, r2);
    write_reg(hsb_pkg::REG_RANGE_THIRD, r3);
    write_reg(hsb_pkg::REG_RANGE_ALPHA, r4);
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [hsb_pkg::CHAN_W-1:0] rand_chan(longint rng);
    longint v;
    case ($urandom_range(0, 7))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      2: return 24'(rng * $urandom_range(0, 6) / 6);
      default: begin
        v = longint'($urandom_range(0, 32'(2 * rng + 1))) - rng / 2;
        return 24'(v);
      end
    endcase
  endfunction

  task automatic random_items(input int n);
    hsb_pkg::req_t r;
    repeat (n) begin
      r.opcode = ($urandom_range(0, 99) < 15) ? OP_GRAY : OP_COLOR;
      r.chan_a = rand_chan(sb.ranges[0]);
      r.chan_b = rand_chan(sb.ranges[1]);
      r.chan_c = rand_chan(sb.ranges[2]);
      r.alpha_value = rand_chan(sb.ranges[3]);
      send(r);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_fields(OP_COLOR, 0, 0, 0, 0);
    send_fields(OP_COLOR, 65280, 65280, 65280, 65280);
    send_fields(OP_COLOR, 32640, 1, 65279, 65281);
    send_fields(OP_COLOR, 8388607, 8388607, 8388607, 8388607);
    send_fields(OP_COLOR, -8388608, -8388608, -8388608, -8388608);
    send_fields(OP_COLOR, -1, -256, 100, 1);
    send_fields(OP_GRAY, 12345, -999, 32640, 40000);
    send_fields(OP_GRAY, -8388608, 8388607, -5, 8388607);
    random_items(100);

    configure(MODE_HSB, 1536, 256, 256, 256);
    idle_enable = 1'b0;
    for (int k = 0; k <= 6; k++) send_fields(OP_COLOR, k * 256, 256, 256, 128);
    send_fields(OP_COLOR, -1, 200, 256, 256);
    send_fields(OP_COLOR, 1535, 128, 200, 0);
    send_fields(OP_COLOR, -8388608, 256, 256, 256);
    send_fields(OP_GRAY, 700, 256, 128, 256);
    random_items(150);
    idle_enable = 1'b1;

    configure(MODE_HSB, 65280, 65280, 65280, 65280);
    random_items(140);

    configure(MODE_HSB, RANGE_MAX, RANGE_MAX, RANGE_MAX, RANGE_MAX);
    random_items(80);

    configure(MODE_RGB, 1, 1, 1, 1);
    random_items(80);

    configure(MODE_HSB, 0, 0, 0, 0);
    send_fields(OP_COLOR, 500, 10, 10, 10);
    send_fields(OP_COLOR, -500, -10, 0, -1);
    random_items(60);

    configure(MODE_RGB, 0, 0, 0, 0);
    random_items(20);

    configure(MODE_HSB, 24'($urandom_range(1, 4096)), 24'($urandom_range(1, 4096)),
              24'($urandom_range(1, 4096)), 24'($urandom_range(1, 4096)));
    random_items(120);

    drain();
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- hsb_rgb_color_resolve.f -----
+incdir+design
design/hsb_pkg.sv
design/hsb_pipe_div.sv
design/hsb_rgb_color_resolve.sv
bench/tb_hsb_rgb_color_resolve.sv
